### hw/rtl/vtab_pkg.sv
// shared types, codes and defaults for the vertex-triangle adjacency builder
package vtab_pkg;

    // fixed field widths
    localparam int VTX_W  = 10;
    localparam int IDX_W  = 12;
    localparam int DATA_W = 12;
    localparam int OP_W   = 3;
    localparam int ST_W   = 3;
    localparam int VCNT_W = 11;

    // default sizes
    localparam int MAX_VERTICES_DEF  = 1024;
    localparam int MAX_TRIANGLES_DEF = 1024;

    localparam logic [VCNT_W-1:0] VCNT_RESET = 11'd1024;

    // opcodes
    localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
    localparam logic [OP_W-1:0] OP_BUILD   = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_OFF  = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_LIST = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    // status codes
    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_VERTEX    = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
    localparam logic [ST_W-1:0] ST_INDEX     = 3'd3;
    localparam logic [ST_W-1:0] ST_NOT_BUILT = 3'd4;

    // classified command passed from front to back
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic               bad_vtx;
        logic               bad_idx;
        logic [3*VTX_W-1:0] corners;  // {c, b, a}
        logic [IDX_W-1:0]   idx;
    } t_cmd;

endpackage

### hw/rtl/vertex_triangle_adjacency_builder.sv
// top level of the vertex-triangle adjacency builder
// add, clear, unknown opcodes: via queue and result register, one item a cycle if i_m_tready
// reads: via queue, registered memory read and result register
// build: check, clear, count, prefix-sum and scatter passes, the count and scatter
//   passes doing a read-modify-write walk of the single count/cursor memory
// reset clears the triangle count, the built flag, the queue and the result register
//   and loads the vertex count with 1024
module vertex_triangle_adjacency_builder #(
    parameter int MAX_VERTICES  = vtab_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = vtab_pkg::MAX_TRIANGLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vtab_pkg::VCNT_W-1:0]   i_cfg_wdata,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [47:0]                   i_s_tdata,  // vertex_a, vertex_b, vertex_c, read_index
    input  logic [vtab_pkg::OP_W-1:0]     i_s_tuser,  // opcode
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [15:0]                   o_m_tdata,  // read_data
    output logic [vtab_pkg::ST_W-1:0]     o_m_tuser   // status
);

    localparam int NW = $clog2(MAX_VERTICES + 1);

    vtab_pkg::t_cmd              f_cmd;
    vtab_pkg::t_cmd              q_cmd;
    logic [NW-1:0]               nv;
    logic                        q_full;
    logic                        q_valid;
    logic                        pop;
    logic [vtab_pkg::DATA_W-1:0] data;

    vtab_front #(
        .MAX_VERTICES (MAX_VERTICES),
        .NW           (NW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_cmd       (f_cmd),
        .o_nv        (nv)
    );

    // input transfer goes straight into the queue
    assign o_s_tready = !q_full;

    vtab_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_s_tvalid && !q_full),
        .i_cmd   (f_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_cmd   (q_cmd),
        .o_valid (q_valid)
    );

    vtab_back #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .NW            (NW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nv        (nv),
        .i_cfg_wr    (i_cfg_we),
        .i_cmd       (q_cmd),
        .i_cmd_valid (q_valid),
        .o_pop       (pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (data),
        .o_status    (o_m_tuser)
    );

    assign o_m_tdata = 16'(data);

endmodule

### hw/rtl/vtab_front.sv
// front end: vertex count register, input unpacking and range classification
module vtab_front #(
    parameter int MAX_VERTICES = vtab_pkg::MAX_VERTICES_DEF,
    parameter int NW           = $clog2(MAX_VERTICES + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [vtab_pkg::VCNT_W-1:0] i_cfg_wdata,
    input  logic [47:0]               i_s_tdata,
    input  logic [vtab_pkg::OP_W-1:0] i_s_tuser,
    output vtab_pkg::t_cmd            o_cmd,
    output logic [NW-1:0]             o_nv
);

    logic [vtab_pkg::VCNT_W-1:0] r_vertex_count;
    logic [31:0]                 vc32;
    logic [31:0]                 nv32;
    logic [vtab_pkg::VTX_W-1:0]  va, vb, vc;
    logic [vtab_pkg::IDX_W-1:0]  idx;

    // vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= vtab_pkg::VCNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // effective vertex count, clipped to the table size
    always_comb begin
        vc32 = 32'(r_vertex_count);
        nv32 = (vc32 > 32'(MAX_VERTICES)) ? 32'(MAX_VERTICES) : vc32;
    end
    assign o_nv = NW'(nv32);

    // unpack and classify
    assign va  = i_s_tdata[9:0];
    assign vb  = i_s_tdata[19:10];
    assign vc  = i_s_tdata[29:20];
    assign idx = i_s_tdata[41:30];

    always_comb begin
        o_cmd.op      = i_s_tuser;
        o_cmd.corners = {vc, vb, va};
        o_cmd.idx     = idx;
        o_cmd.bad_vtx = (32'(va) >= nv32) || (32'(vb) >= nv32) || (32'(vc) >= nv32);
        o_cmd.bad_idx = 32'(idx) > nv32;
    end

endmodule

### hw/rtl/vtab_queue.sv
// two-entry command queue between front and back
module vtab_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vtab_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output vtab_pkg::t_cmd o_cmd,
    output logic           o_valid
);

    vtab_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

### hw/rtl/vtab_back.sv
// back end: command sequencer, table memories and result register
module vtab_back #(
    parameter int MAX_VERTICES  = vtab_pkg::MAX_VERTICES_DEF,
    parameter int MAX_TRIANGLES = vtab_pkg::MAX_TRIANGLES_DEF,
    parameter int NW            = $clog2(MAX_VERTICES + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [NW-1:0]               i_nv,
    input  logic                        i_cfg_wr,
    input  vtab_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [vtab_pkg::DATA_W-1:0] o_data,
    output logic [vtab_pkg::ST_W-1:0]   o_status
);

    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW  = $clog2(MAX_TRIANGLES + 1);
    localparam int VAW = $clog2(MAX_VERTICES);
    localparam int OAW = $clog2(MAX_VERTICES + 1);
    localparam int LD  = 3 * MAX_TRIANGLES;
    localparam int LAW = $clog2(LD);
    localparam int OW  = $clog2(LD + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CHK    = 4'd1;
    localparam logic [3:0] S_CHK_EV = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_CNT    = 4'd4;
    localparam logic [3:0] S_CNT_LD = 4'd5;
    localparam logic [3:0] S_CNT_RD = 4'd6;
    localparam logic [3:0] S_CNT_WR = 4'd7;
    localparam logic [3:0] S_PFX_RD = 4'd8;
    localparam logic [3:0] S_PFX_WR = 4'd9;
    localparam logic [3:0] S_SC     = 4'd10;
    localparam logic [3:0] S_SC_LD  = 4'd11;
    localparam logic [3:0] S_SC_RD  = 4'd12;
    localparam logic [3:0] S_SC_WR  = 4'd13;
    localparam logic [3:0] S_RD_OFF = 4'd14;
    localparam logic [3:0] S_RD_LST = 4'd15;

    function automatic logic [9:0] corner_of(input logic [29:0] c, input logic [1:0] k);
        logic [9:0] r;
        case (k)
            2'd0:    r = c[9:0];
            2'd1:    r = c[19:10];
            default: r = c[29:20];
        endcase
        return r;
    endfunction

    // memories
    logic [29:0]    m_tri [MAX_TRIANGLES];
    logic [OW-1:0]  m_cnt [MAX_VERTICES];
    logic [OW-1:0]  m_off [MAX_VERTICES+1];
    logic [TAW-1:0] m_lst [LD];

    logic [29:0]    r_tri_q;
    logic [OW-1:0]  r_cnt_q;
    logic [OW-1:0]  r_off_q;
    logic [TAW-1:0] r_lst_q;

    logic           tri_we;
    logic [TAW-1:0] tri_waddr, tri_raddr;
    logic           cnt_we;
    logic [VAW-1:0] cnt_waddr, cnt_raddr;
    logic [OW-1:0]  cnt_wdata;
    logic           off_we;
    logic [OAW-1:0] off_waddr, off_raddr;
    logic [OW-1:0]  off_wdata;
    logic           lst_we;
    logic [LAW-1:0] lst_waddr, lst_raddr;

    // control registers
    logic [3:0]     r_state,     n_state;
    logic [CW-1:0]  r_tri_total, n_tri_total;
    logic           r_built,     n_built;
    logic [CW-1:0]  r_t,         n_t;
    logic [1:0]     r_k,         n_k;
    logic [NW-1:0]  r_v,         n_v;
    logic [OW-1:0]  r_sum,       n_sum;
    logic [OW-1:0]  r_list_total, n_list_total;
    logic [29:0]    r_corners,   n_corners;
    logic           r_out_valid, n_out_valid;
    logic [vtab_pkg::DATA_W-1:0] r_out_data, n_out_data;
    logic [vtab_pkg::ST_W-1:0]   r_out_status, n_out_status;

    logic [9:0]     cur_v;
    logic [29:0]    cv_chk;

    assign cur_v  = corner_of(r_corners, r_k);
    assign cv_chk = r_tri_q;
    assign o_pop  = (r_state == S_IDLE) && i_cmd_valid && (!r_out_valid || i_ready);

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_tri_total  = r_tri_total;
        n_built      = r_built;
        n_t          = r_t;
        n_k          = r_k;
        n_v          = r_v;
        n_sum        = r_sum;
        n_list_total = r_list_total;
        n_corners    = r_corners;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;

        tri_we    = 1'b0;
        tri_waddr = TAW'(r_tri_total);
        tri_raddr = TAW'(r_t);
        cnt_we    = 1'b0;
        cnt_waddr = VAW'(cur_v);
        cnt_wdata = r_cnt_q + OW'(1);
        cnt_raddr = VAW'(cur_v);
        off_we    = 1'b0;
        off_waddr = OAW'(r_v);
        off_wdata = r_sum;
        off_raddr = OAW'(i_cmd.idx);
        lst_we    = 1'b0;
        lst_waddr = LAW'(r_cnt_q);
        lst_raddr = LAW'(i_cmd.idx);

        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_out_data   = '0;
                    n_out_status = vtab_pkg::ST_OK;
                    case (i_cmd.op)
                        vtab_pkg::OP_ADD: begin
                            n_out_valid = 1'b1;
                            if (i_cmd.bad_vtx) begin
                                n_out_status = vtab_pkg::ST_VERTEX;
                            end else if (32'(r_tri_total) >= 32'(MAX_TRIANGLES)) begin
                                n_out_status = vtab_pkg::ST_FULL;
                            end else begin
                                tri_we      = 1'b1;
                                n_tri_total = r_tri_total + CW'(1);
                                n_built     = 1'b0;
                            end
                        end
                        vtab_pkg::OP_BUILD: begin
                            n_t     = '0;
                            n_state = S_CHK;
                        end
                        vtab_pkg::OP_RD_OFF: begin
                            if (!r_built) begin
                                n_out_valid  = 1'b1;
                                n_out_status = vtab_pkg::ST_NOT_BUILT;
                            end else if (i_cmd.bad_idx) begin
                                n_out_valid  = 1'b1;
                                n_out_status = vtab_pkg::ST_INDEX;
                            end else begin
                                n_state = S_RD_OFF;
                            end
                        end
                        vtab_pkg::OP_RD_LIST: begin
                            if (!r_built) begin
                                n_out_valid  = 1'b1;
                                n_out_status = vtab_pkg::ST_NOT_BUILT;
                            end else if (32'(i_cmd.idx) >= 32'(r_list_total) ||
                                         32'(i_cmd.idx) >= 32'(LD)) begin
                                n_out_valid  = 1'b1;
                                n_out_status = vtab_pkg::ST_INDEX;
                            end else begin
                                n_state = S_RD_LST;
                            end
                        end
                        vtab_pkg::OP_CLEAR: begin
                            n_out_valid = 1'b1;
                            n_tri_total = '0;
                            n_built     = 1'b0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            // check stored corners against the current vertex count
            S_CHK: begin
                if (r_t == r_tri_total) begin
                    n_v     = '0;
                    n_state = S_CLR;
                end else begin
                    n_state = S_CHK_EV;
                end
            end
            S_CHK_EV: begin
                if (32'(cv_chk[9:0]) >= 32'(i_nv) || 32'(cv_chk[19:10]) >= 32'(i_nv) ||
                    32'(cv_chk[29:20]) >= 32'(i_nv)) begin
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = vtab_pkg::ST_VERTEX;
                    n_state      = S_IDLE;
                end else begin
                    n_t     = r_t + CW'(1);
                    n_state = S_CHK;
                end
            end
            // zero the counts
            S_CLR: begin
                if (r_v == i_nv) begin
                    n_t     = '0;
                    n_state = S_CNT;
                end else begin
                    cnt_we    = 1'b1;
                    cnt_waddr = VAW'(r_v);
                    cnt_wdata = '0;
                    n_v       = r_v + NW'(1);
                end
            end
            // count corner uses
            S_CNT: begin
                if (r_t == r_tri_total) begin
                    n_v     = '0;
                    n_sum   = '0;
                    n_state = S_PFX_RD;
                end else begin
                    n_k     = 2'd0;
                    n_state = S_CNT_LD;
                end
            end
            S_CNT_LD: begin
                n_corners = r_tri_q;
                n_state   = S_CNT_RD;
            end
            S_CNT_RD: begin
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                cnt_we = 1'b1;
                if (r_k == 2'd2) begin
                    n_t     = r_t + CW'(1);
                    n_state = S_CNT;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_CNT_RD;
                end
            end
            // exclusive prefix sum into offsets and cursors
            S_PFX_RD: begin
                cnt_raddr = VAW'(r_v);
                if (r_v == i_nv) begin
                    off_we       = 1'b1;
                    n_list_total = r_sum;
                    n_t          = '0;
                    n_state      = S_SC;
                end else begin
                    n_state = S_PFX_WR;
                end
            end
            S_PFX_WR: begin
                off_we    = 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = VAW'(r_v);
                cnt_wdata = r_sum;
                n_sum     = r_sum + r_cnt_q;
                n_v       = r_v + NW'(1);
                n_state   = S_PFX_RD;
            end
            // scatter triangle numbers
            S_SC: begin
                if (r_t == r_tri_total) begin
                    n_built      = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_data   = '0;
                    n_out_status = vtab_pkg::ST_OK;
                    n_state      = S_IDLE;
                end else begin
                    n_k     = 2'd0;
                    n_state = S_SC_LD;
                end
            end
            S_SC_LD: begin
                n_corners = r_tri_q;
                n_state   = S_SC_RD;
            end
            S_SC_RD: begin
                n_state = S_SC_WR;
            end
            S_SC_WR: begin
                cnt_we = 1'b1;
                lst_we = (32'(r_cnt_q) < 32'(LD));
                if (r_k == 2'd2) begin
                    n_t     = r_t + CW'(1);
                    n_state = S_SC;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_SC_RD;
                end
            end
            S_RD_OFF: begin
                n_out_valid  = 1'b1;
                n_out_data   = vtab_pkg::DATA_W'(r_off_q);
                n_out_status = vtab_pkg::ST_OK;
                n_state      = S_IDLE;
            end
            S_RD_LST: begin
                n_out_valid  = 1'b1;
                n_out_data   = vtab_pkg::DATA_W'(r_lst_q);
                n_out_status = vtab_pkg::ST_OK;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tri_total <= '0;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_tri_total <= n_tri_total;
            r_built     <= i_cfg_wr ? 1'b0 : n_built;
            r_out_valid <= n_out_valid;
        end
    end

    // loop counters and payload
    always_ff @(posedge i_clk) begin
        r_t          <= n_t;
        r_k          <= n_k;
        r_v          <= n_v;
        r_sum        <= n_sum;
        r_list_total <= n_list_total;
        r_corners    <= n_corners;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
    end

    // triangle store
    always_ff @(posedge i_clk) begin
        if (tri_we) m_tri[tri_waddr] <= i_cmd.corners;
        r_tri_q <= m_tri[tri_raddr];
    end

    // counts and fill cursors
    always_ff @(posedge i_clk) begin
        if (cnt_we) m_cnt[cnt_waddr] <= cnt_wdata;
        r_cnt_q <= m_cnt[cnt_raddr];
    end

    // offset table
    always_ff @(posedge i_clk) begin
        if (off_we) m_off[off_waddr] <= off_wdata;
        r_off_q <= m_off[off_raddr];
    end

    // adjacency list
    always_ff @(posedge i_clk) begin
        if (lst_we) m_lst[lst_waddr] <= TAW'(r_t);
        r_lst_q <= m_lst[lst_raddr];
    end

    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_status = r_out_status;

endmodule

### hw/rtl/vtab_checker.sv
// port-level checks for the adjacency builder, bound to the top level
module vtab_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [2:0]  o_m_tuser
);

    // a pending result stays until its transfer
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped before transfer");

    // error results carry zero data
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != vtab_pkg::ST_OK) |-> (o_m_tdata == 16'd0))
        else $error("error result with nonzero data");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind vertex_triangle_adjacency_builder vtab_port_checks u_vtab_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

### verif/vtab_checker.sv
// checker for the adjacency builder: watches both streams, predicts results, compares
module vtab_checker
    import vtab_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [VCNT_W-1:0] i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [47:0]       i_s_tdata,
    input  logic [OP_W-1:0]   i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [15:0]       i_m_tdata,
    input  logic [ST_W-1:0]   i_m_tuser,
    output int                o_fail_count,
    output int                o_pending
);

    localparam int NV_MAX = MAX_VERTICES_DEF;
    localparam int NT_MAX = MAX_TRIANGLES_DEF;

    typedef struct packed {
        logic [DATA_W-1:0] rd_data;
        logic [ST_W-1:0]   status;
    } t_answer;

    // mirror of the block state
    logic [3*VTX_W-1:0] tri_mem [NT_MAX];
    int                 tri_total;
    int                 offsets [NV_MAX+1];
    int                 cursor [NV_MAX];
    logic [VTX_W-1:0]   adj_list [3*NT_MAX];
    bit                 built;
    logic [VCNT_W-1:0]  vcount;
    t_answer            answers_due [$];

    function automatic int live_vertices();
        return (vcount > NV_MAX) ? NV_MAX : int'(vcount);
    endfunction

    // corner check, then counting sort into offsets and adjacency list
    function automatic logic [ST_W-1:0] build_adjacency();
        int nv;
        int sum;
        int cnt;
        int vx;
        nv = live_vertices();
        for (int t = 0; t < tri_total; t++)
            for (int k = 0; k < 3; k++)
                if (int'(tri_mem[t][k*VTX_W +: VTX_W]) >= nv) return ST_VERTEX;
        for (int v = 0; v <= nv; v++) offsets[v] = 0;
        for (int t = 0; t < tri_total; t++)
            for (int k = 0; k < 3; k++) offsets[tri_mem[t][k*VTX_W +: VTX_W]]++;
        sum = 0;
        for (int v = 0; v < nv; v++) begin
            cnt = offsets[v];
            offsets[v] = sum;
            cursor[v] = sum;
            sum += cnt;
        end
        offsets[nv] = sum;
        for (int t = 0; t < tri_total; t++)
            for (int k = 0; k < 3; k++) begin
                vx = tri_mem[t][k*VTX_W +: VTX_W];
                adj_list[cursor[vx]] = VTX_W'(t);
                cursor[vx]++;
            end
        built = 1;
        return ST_OK;
    endfunction

    function automatic t_answer predict_answer(logic [OP_W-1:0] op, logic [47:0] d);
        t_answer ans;
        int nv;
        int idx;
        logic [VTX_W-1:0] va, vb, vc;
        ans = '0;
        nv = live_vertices();
        va = d[9:0];
        vb = d[19:10];
        vc = d[29:20];
        idx = d[41:30];
        case (op)
            OP_ADD: begin
                if (va >= nv || vb >= nv || vc >= nv) begin
                    ans.status = ST_VERTEX;
                end else if (tri_total >= NT_MAX) begin
                    ans.status = ST_FULL;
                end else begin
                    tri_mem[tri_total] = {vc, vb, va};
                    tri_total++;
                    built = 0;
                end
            end
            OP_BUILD: ans.status = build_adjacency();
            OP_RD_OFF: begin
                if (!built) ans.status = ST_NOT_BUILT;
                else if (idx > nv) ans.status = ST_INDEX;
                else ans.rd_data = DATA_W'(offsets[idx]);
            end
            OP_RD_LIST: begin
                if (!built) ans.status = ST_NOT_BUILT;
                else if (idx >= offsets[nv] || idx >= 3*NT_MAX) ans.status = ST_INDEX;
                else ans.rd_data = DATA_W'(adj_list[idx]);
            end
            OP_CLEAR: begin
                tri_total = 0;
                built = 0;
            end
            default: ;
        endcase
        return ans;
    endfunction

    function automatic void note_failure(string what, t_answer want, t_answer got);
        if (o_fail_count < 10)
            $display("mismatch %s: expected data %0d status %0d, got data %0d status %0d",
                     what, want.rd_data, want.status, got.rd_data, got.status);
        o_fail_count++;
    endfunction

    assign o_pending = answers_due.size();

    initial o_fail_count = 0;

    // predict on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        t_answer fresh;
        if (!i_rst_n) begin
            tri_total = 0;
            built = 0;
            vcount = VCNT_RESET;
            answers_due.delete();
        end else begin
            if (i_cfg_we) begin
                vcount = i_cfg_wdata;
                built = 0;
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh = predict_answer(i_s_tuser, i_s_tdata);
                answers_due.insert(answers_due.size(), fresh);
            end
            if (i_m_tvalid && i_m_tready) begin
                got.rd_data = i_m_tdata[DATA_W-1:0];
                got.status = i_m_tuser;
                if (answers_due.size() == 0) begin
                    note_failure("unexpected transfer", '0, got);
                end else begin
                    want = answers_due.pop_front();
                    if (got.rd_data !== want.rd_data) note_failure("read_data", want, got);
                    else if (got.status !== want.status) note_failure("status", want, got);
                end
            end
        end
    end

endmodule

### verif/tb_vertex_triangle_adjacency_builder.sv
// testbench top: stimulus, flow control and verdict for the adjacency builder
module tb_vertex_triangle_adjacency_builder;
    import vtab_pkg::*;

    logic              i_clk = 0;
    logic              i_rst_n = 0;
    logic              i_cfg_we = 0;
    logic [VCNT_W-1:0] i_cfg_wdata = '0;
    logic              i_s_tvalid = 0;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata = '0;  // vertex_a, vertex_b, vertex_c, read_index
    logic [OP_W-1:0]   i_s_tuser = '0;  // opcode
    logic              o_m_tvalid;
    logic              i_m_tready = 0;
    logic [15:0]       o_m_tdata;       // read_data
    logic [ST_W-1:0]   o_m_tuser;       // status

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int live_nv = 1024;

    always #5 i_clk = ~i_clk;

    vertex_triangle_adjacency_builder i_dut (.*);

    vtab_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_s_tvalid, .i_s_tready(o_s_tready), .i_s_tdata, .i_s_tuser,
        .i_m_tvalid(o_m_tvalid), .i_m_tready, .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver back-pressure
    always @(posedge i_clk) i_m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // run limit
    initial begin
        #30000000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send(logic [OP_W-1:0] op, logic [9:0] va, logic [9:0] vb,
                        logic [9:0] vc, logic [11:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1;
        i_s_tuser <= op;
        i_s_tdata <= {6'd0, idx, vc, vb, va};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic drain();
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_vcount(logic [VCNT_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        live_nv = (v > 1024) ? 1024 : int'(v);
    endtask

    function automatic logic [9:0] pick_vertex();
        if (live_nv == 0 || $urandom_range(19) == 0) return 10'($urandom_range(1023));
        return 10'($urandom_range(live_nv - 1));
    endfunction

    // one mesh: optional clear, up to 12 triangles, build, reads and some noise
    task automatic mesh_round();
        int ntri;
        int nrd;
        ntri = $urandom_range(12);
        nrd = $urandom_range(4, 10);
        if ($urandom_range(9) < 7) send(OP_CLEAR, 10'($urandom), 10'($urandom), 10'($urandom),
                                        12'($urandom));
        if ($urandom_range(7) == 0) send(OP_RD_OFF, 0, 0, 0, 12'($urandom_range(4)));
        repeat (ntri) send(OP_ADD, pick_vertex(), pick_vertex(), pick_vertex(), 12'($urandom));
        send(OP_BUILD, 10'($urandom), 10'($urandom), 10'($urandom), 12'($urandom));
        repeat (nrd) begin
            case ($urandom_range(9))
                0: send(OP_RD_OFF, 0, 0, 0, 12'($urandom));
                1: send(OP_RD_LIST, 0, 0, 0, 12'($urandom));
                2: send(3'($urandom_range(5, 7)), 10'($urandom), 10'($urandom),
                        10'($urandom), 12'($urandom));
                3, 4, 5: send(OP_RD_OFF, 0, 0, 0, 12'($urandom_range(live_nv + 1)));
                default: send(OP_RD_LIST, 0, 0, 0, 12'($urandom_range(3 * ntri + 2)));
            endcase
        end
        if ($urandom_range(9) == 0) begin
            send(OP_ADD, pick_vertex(), pick_vertex(), pick_vertex(), 0);
            send(OP_RD_LIST, 0, 0, 0, 0);
        end
    endtask

    initial begin
        logic [VCNT_W-1:0] setting [4][2];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reads before build, empty build, extremes, unknown opcodes
        send(OP_RD_OFF, 0, 0, 0, 0);
        send(OP_RD_LIST, 0, 0, 0, 0);
        send(OP_BUILD, 0, 0, 0, 0);
        send(OP_RD_OFF, 0, 0, 0, 0);
        send(OP_RD_OFF, 0, 0, 0, 12'd1025);
        send(OP_RD_OFF, 0, 0, 0, 12'hFFF);
        send(OP_RD_LIST, 0, 0, 0, 0);
        send(OP_ADD, 0, 0, 0, 0);
        send(OP_ADD, 10'h3FF, 10'h3FF, 10'h3FF, 12'hFFF);
        send(OP_ADD, 10'h3FF, 0, 10'd512, 0);
        send(OP_BUILD, 0, 0, 0, 0);
        send(OP_RD_OFF, 0, 0, 0, 12'd1023);
        send(OP_RD_OFF, 0, 0, 0, 12'd1024);
        send(OP_RD_LIST, 0, 0, 0, 12'd3);
        send(OP_RD_LIST, 0, 0, 0, 12'd8);
        send(OP_RD_LIST, 0, 0, 0, 12'd9);
        for (int op = 5; op < 8; op++) send(3'(op), 10'h3FF, 10'h3FF, 10'h3FF, 12'hFFF);
        send(OP_CLEAR, 0, 0, 0, 0);
        send(OP_RD_OFF, 0, 0, 0, 0);
        // stale corner after shrinking the vertex count, then a bad corner on add
        send(OP_ADD, 10'd900, 10'd1, 10'd2, 0);
        set_vcount(11'd4);
        send(OP_BUILD, 0, 0, 0, 0);
        send(OP_ADD, 10'd4, 0, 0, 0);
        send(OP_CLEAR, 0, 0, 0, 0);

        // fill the store completely, overflow it, build the full table
        set_vcount(11'd1024);
        repeat (1024) send(OP_ADD, pick_vertex(), pick_vertex(), pick_vertex(), 0);
        send(OP_ADD, 1, 2, 3, 0);
        send(OP_BUILD, 0, 0, 0, 0);
        repeat (20) send(OP_RD_OFF, 0, 0, 0, 12'($urandom_range(1025)));
        repeat (20) send(OP_RD_LIST, 0, 0, 0, 12'($urandom_range(3071)));
        send(OP_RD_LIST, 0, 0, 0, 12'd3072);
        send(OP_CLEAR, 0, 0, 0, 0);

        // random phases with different flow control and settings
        setting[0] = '{11'd1024, 11'd3};
        setting[1] = '{11'd1, 11'd2047};
        setting[2] = '{11'd0, 11'($urandom_range(2, 1024))};
        setting[3] = '{11'($urandom_range(2047)), 11'd16};
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 87; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 87; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int s = 0; s < 2; s++) begin
                set_vcount(setting[ph][s]);
                repeat (6) mesh_round();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### vertex_triangle_adjacency_builder.f
hw/rtl/vtab_pkg.sv
hw/rtl/vtab_front.sv
hw/rtl/vtab_queue.sv
hw/rtl/vtab_back.sv
hw/rtl/vertex_triangle_adjacency_builder.sv
hw/rtl/vtab_checker.sv
verif/vtab_checker.sv
verif/tb_vertex_triangle_adjacency_builder.sv
